>>> src/lpam_pkg.sv
// Shared types and constants for the largest-prime-at-most search block.
// Used by the controller, the datapath and the top level; no dependencies.
package lpam_pkg;

	localparam int unsigned OUT_WIDTH = 32;
	localparam int unsigned FIRST_DIV = 3;
	localparam int unsigned DIV_STEP  = 2;
	localparam int unsigned CAND_STEP = 2;
	localparam int unsigned SMALL_MAX = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TEST,
		ST_DIV,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_bound;
		logic start_scan;
		logic start_div;
		logic div_step;
		logic next_cand;
		logic next_div;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic cand_small;
		logic sq_over;
		logic rem_zero;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

>>> src/lpam_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle while step is high.
// Depends on nothing outside this file.
module lpam_rem #(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned DIV_WIDTH   = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   step,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [DIV_WIDTH-1:0]   divisor,
	output logic [DIV_WIDTH-1:0]   rem,
	output logic                   last
);

	localparam int unsigned CW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] shift_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [CW-1:0]          cnt_q;
	logic [DIV_WIDTH:0]     trial;
	logic [DIV_WIDTH:0]     diff;

	assign trial = {rem_q, shift_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign last  = (cnt_q == CW'(VALUE_WIDTH - 1));
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (step) begin
			shift_q <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[DIV_WIDTH-1:0];
			end else begin
				rem_q <= trial[DIV_WIDTH-1:0];
			end
		end
	end

endmodule

>>> src/lpam_datapath.sv
// Datapath: candidate, trial divisor and its square, remainder unit, result register.
// Depends on lpam_pkg and lpam_rem.
module lpam_datapath #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpam_pkg::cmd_t                      cmd,
	output lpam_pkg::status_t                   status,
	input  logic [VALUE_WIDTH-1:0]              upper_bound,
	output logic                                prime_valid,
	input  logic                                prime_stall,
	output logic [lpam_pkg::OUT_WIDTH-1:0]      prime_found
);

	localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 2;
	localparam int unsigned SW = VALUE_WIDTH + 2;

	logic [VALUE_WIDTH-1:0]         cand_q;
	logic [DW-1:0]                  div_q;
	logic [SW-1:0]                  sq_q;
	logic [lpam_pkg::OUT_WIDTH-1:0] prime_q;
	logic                           out_valid_q;
	logic [DW-1:0]                  rem;
	logic                           rem_last;

	lpam_rem #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIV_WIDTH  (DW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start_div),
		.step    (cmd.div_step),
		.dividend(cand_q),
		.divisor (div_q),
		.rem     (rem),
		.last    (rem_last)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_bound) begin
			cand_q <= upper_bound[0] ? upper_bound : upper_bound - VALUE_WIDTH'(1);
		end else if (cmd.next_cand) begin
			cand_q <= cand_q - VALUE_WIDTH'(lpam_pkg::CAND_STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			div_q <= DW'(lpam_pkg::FIRST_DIV);
			sq_q  <= SW'(lpam_pkg::FIRST_DIV * lpam_pkg::FIRST_DIV);
		end else if (cmd.next_div) begin
			div_q <= div_q + DW'(lpam_pkg::DIV_STEP);
			sq_q  <= sq_q + SW'({div_q, 2'b00}) + SW'(4);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			prime_q <= lpam_pkg::OUT_WIDTH'(cand_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!prime_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.cand_small = (cand_q <= VALUE_WIDTH'(lpam_pkg::SMALL_MAX));
		status.sq_over    = (sq_q > SW'(cand_q));
		status.rem_zero   = (rem == '0);
		status.div_last   = rem_last;
		status.out_free   = !out_valid_q || !prime_stall;
	end

	assign prime_valid = out_valid_q;
	assign prime_found = prime_q;

endmodule

>>> src/lpam_ctrl.sv
// Controller state machine sequencing candidates and trial divisors.
// Depends on lpam_pkg; drives the datapath through cmd_t, reads status_t.
module lpam_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bound_valid,
	output logic                bound_stall,
	input  lpam_pkg::status_t   status,
	output lpam_pkg::cmd_t      cmd
);

	lpam_pkg::state_t state_q;
	lpam_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpam_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpam_pkg::ST_IDLE: begin
				if (bound_valid) state_d = lpam_pkg::ST_CHECK;
			end
			lpam_pkg::ST_CHECK: begin
				state_d = status.cand_small ? lpam_pkg::ST_FINISH : lpam_pkg::ST_TEST;
			end
			lpam_pkg::ST_TEST: begin
				state_d = status.sq_over ? lpam_pkg::ST_FINISH : lpam_pkg::ST_DIV;
			end
			lpam_pkg::ST_DIV: begin
				if (status.div_last) state_d = lpam_pkg::ST_EVAL;
			end
			lpam_pkg::ST_EVAL: begin
				state_d = status.rem_zero ? lpam_pkg::ST_CHECK : lpam_pkg::ST_TEST;
			end
			lpam_pkg::ST_FINISH: begin
				if (status.out_free) state_d = lpam_pkg::ST_IDLE;
			end
			default: state_d = lpam_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		bound_stall = 1'b1;
		unique case (state_q)
			lpam_pkg::ST_IDLE: begin
				bound_stall    = 1'b0;
				cmd.load_bound = bound_valid;
			end
			lpam_pkg::ST_CHECK: begin
				cmd.start_scan = !status.cand_small;
			end
			lpam_pkg::ST_TEST: begin
				cmd.start_div = !status.sq_over;
			end
			lpam_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			lpam_pkg::ST_EVAL: begin
				cmd.next_cand = status.rem_zero;
				cmd.next_div  = !status.rem_zero;
			end
			lpam_pkg::ST_FINISH: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				bound_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> src/largest_prime_at_most.sv
// Largest odd number at or below a bound with no odd divisor up to its square root.
// An even bound first drops by one (0 wraps to all ones); bounds 1 and 2 give 1.
// One beat in gives one beat out. A search tries candidates downward by two; each
// trial divisor is tested by the bit-serial remainder unit, which retires one
// dividend bit per cycle, and divisors run upward from 3 in steps of two up to the
// candidate's square root. One search runs at a time; the next bound is taken as
// soon as the finished result sits in the output register, even while that result
// is still stalled.
// Depends on lpam_pkg, lpam_ctrl, lpam_datapath and lpam_rem.
module largest_prime_at_most #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              bound_valid,
	output logic                              bound_stall,
	input  logic [31:0]                       upper_bound,
	output logic                              prime_valid,
	input  logic                              prime_stall,
	output logic [lpam_pkg::OUT_WIDTH-1:0]    prime_found
);

	lpam_pkg::cmd_t    cmd;
	lpam_pkg::status_t status;

	lpam_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.bound_valid(bound_valid),
		.bound_stall(bound_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lpam_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.upper_bound(upper_bound[VALUE_WIDTH-1:0]),
		.prime_valid(prime_valid),
		.prime_stall(prime_stall),
		.prime_found(prime_found)
	);

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_bound, cmd.start_div, cmd.div_step, cmd.next_cand,
			cmd.next_div, cmd.load_out}))
		else $error("controller issued conflicting commands");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(bound_valid && !bound_stall) |=> bound_stall)
		else $error("bound taken while a search was starting");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> prime_valid)
		else $error("loaded result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(prime_valid && prime_stall) |-> !cmd.load_out)
		else $error("pending result overwritten");

endmodule

>>> bench/testbench.sv
// Testbench for largest_prime_at_most: bursty bound beats against a stalling receiver.
// Each bound is checked against a trial-division search kept here.
// Depends on lpam_pkg and largest_prime_at_most.
module testbench;

	localparam int unsigned VALUE_WIDTH = 32;
	localparam int unsigned RANDOM_BOUNDS = 81;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_CYCLES = 200;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                bound_valid = 1'b0;
	logic                                bound_stall;
	logic [31:0]                         upper_bound = '0;
	logic                                prime_valid;
	logic                                prime_stall = 1'b0;
	logic [lpam_pkg::OUT_WIDTH-1:0]      prime_found;

	logic [31:0]                         pending_bounds[$];
	logic [lpam_pkg::OUT_WIDTH-1:0]      expected_primes[$];
	int unsigned                         burst_left = 1;
	int unsigned                         gap_left = 0;
	logic [7:0]                          stall_phase = '0;
	int unsigned                         hold_left = 0;
	logic                                hold_done = 1'b0;
	int unsigned                         results_seen = 0;
	int unsigned                         failures = 0;

	largest_prime_at_most #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.bound_valid(bound_valid),
		.bound_stall(bound_stall),
		.upper_bound(upper_bound),
		.prime_valid(prime_valid),
		.prime_stall(prime_stall),
		.prime_found(prime_found)
	);

	function automatic logic [lpam_pkg::OUT_WIDTH-1:0] largest_prime_le(logic [31:0] bound);
		longint unsigned mask;
		longint unsigned cand;
		longint unsigned d;
		bit              composite;
		mask = (64'd1 << VALUE_WIDTH) - 64'd1;
		cand = bound & mask;
		if (cand[0] == 1'b0)
			cand = (cand - 64'd1) & mask;
		while (cand > lpam_pkg::SMALL_MAX) begin
			composite = 1'b0;
			for (d = lpam_pkg::FIRST_DIV; d * d <= cand && !composite;
					d += lpam_pkg::DIV_STEP)
				if (cand % d == 0)
					composite = 1'b1;
			if (!composite)
				return cand[lpam_pkg::OUT_WIDTH-1:0];
			cand -= lpam_pkg::CAND_STEP;
		end
		return cand[lpam_pkg::OUT_WIDTH-1:0];
	endfunction

	initial forever #2 clk = ~clk;

	initial begin
		#60000000;
		$display("FAIL");
		$finish;
	end

	// sender: bursts of beats with random gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_valid <= 1'b0;
			upper_bound <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!bound_valid || !bound_stall) begin
			if (bound_valid)
				expected_primes.push_back(largest_prime_le(upper_bound));
			if (gap_left != 0) begin
				bound_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_bounds.size() != 0) begin
				bound_valid <= 1'b1;
				upper_bound <= pending_bounds.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end else
					burst_left <= burst_left - 1;
			end else
				bound_valid <= 1'b0;
		end
	end

	// receiver: check each result beat, stall on a rotating pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_stall <= 1'b0;
			stall_phase <= '0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (prime_valid && !prime_stall) begin
				if (expected_primes.size() == 0) begin
					if (failures < 10)
						$display("result beat with nothing expected: prime_found=%0d",
							prime_found);
					failures = failures + 1;
				end else begin
					if (prime_found !== expected_primes[0]) begin
						if (failures < 10)
							$display("prime_found mismatch: expected %0d, got %0d",
								expected_primes[0], prime_found);
						failures = failures + 1;
					end
					void'(expected_primes.pop_front());
				end
				results_seen = results_seen + 1;
			end
			stall_phase <= stall_phase + 1'b1;
			if (hold_left != 0) begin
				prime_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen == 2) begin
				prime_stall <= 1'b1;
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
			end else begin
				case (stall_phase[7:6])
					2'd0: prime_stall <= 1'b0;
					2'd1: prime_stall <= stall_phase[0];
					2'd2: prime_stall <= $urandom_range(0, 1);
					default: prime_stall <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int unsigned w;
		pending_bounds = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
			32'd10, 32'd25, 32'd49, 32'd121, 32'd255, 32'd256, 32'd65536, 32'd65537,
			32'd1018081, 32'd0, 32'hFFFF_FFFF};
		// keep most bounds narrow: search time grows with the square root
		for (int i = 0; i < RANDOM_BOUNDS; i++) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(2, 16);
			pending_bounds.push_back($urandom & ((32'd1 << w) - 32'd1));
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending_bounds.size() != 0 || bound_valid || expected_primes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
